// ===== rtl/core/vunb_pkg.sv =====
package vunb_pkg;

    localparam int NEEDLE_STEPS_DEF = 104;
    localparam int CHANNELS_DEF     = 2;

    localparam int LEVEL_W = 16;
    localparam int INDEX_W = 7;
    localparam int POS_W   = 7;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                       operation;
        logic                      channel;
        logic signed [LEVEL_W-1:0] level_db;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [LEVEL_W-1:0] entry_value;
    } in_beat_t;

    typedef struct packed {
        logic             out_channel;
        logic [POS_W-1:0] needle_position;
        logic [POS_W-1:0] target_position;
    } out_beat_t;

    typedef struct packed {
        logic table_wr;
        logic load;
        logic scan;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic is_write;
        logic chan_ok;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/vu_needle_ballistics_top.sv =====
// channel  dir  handshake          beat
// s_       in   s_valid/s_ready    vunb_pkg::in_beat_t  (sample or table write)
// m_       out  m_valid/m_ready    vunb_pkg::out_beat_t (one per sample on a valid channel)
//
// Table write: no result. Sample: accept, a linear scan of the
// threshold RAM at one entry per cycle (registered read), then a slew step
// that waits until the output register is free. The next accept comes only
// after the slew step; the scan goes through the single read port.
// aresetn is synchronous; it zeroes the needles, the table stays undefined.
// The result sits in an output register; a stalled m_ready holds only the slew.
module vu_needle_ballistics_top #(
    parameter int NEEDLE_STEPS = vunb_pkg::NEEDLE_STEPS_DEF,
    parameter int CHANNELS     = vunb_pkg::CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vunb_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vunb_pkg::out_beat_t m_data
);

    vunb_pkg::dp_cmd_t    cmd;
    vunb_pkg::dp_status_t status;

    vunb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vunb_dp #(
        .NEEDLE_STEPS (NEEDLE_STEPS),
        .CHANNELS     (CHANNELS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ===== rtl/core/vunb_dp.sv =====
module vunb_dp #(
    parameter int NEEDLE_STEPS = vunb_pkg::NEEDLE_STEPS_DEF,
    parameter int CHANNELS     = vunb_pkg::CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vunb_pkg::in_beat_t   s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output vunb_pkg::out_beat_t  m_data,
    input  vunb_pkg::dp_cmd_t    cmd,
    output vunb_pkg::dp_status_t status
);

    localparam int AW = (NEEDLE_STEPS > 1) ? $clog2(NEEDLE_STEPS) : 1;
    localparam int PW = $clog2(NEEDLE_STEPS + 1);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [vunb_pkg::LEVEL_W-1:0] table_mem [NEEDLE_STEPS];

    logic signed [vunb_pkg::LEVEL_W-1:0] level_reg;
    logic                                chan_reg;
    logic [AW-1:0]                       addr_reg, addr_next;
    logic signed [vunb_pkg::LEVEL_W-1:0] rdata_reg;
    logic [AW-1:0]                       ridx_reg;
    logic                                rvalid_reg;
    logic [PW-1:0]                       target_reg;
    logic [PW-1:0]                       needle_reg [CHANNELS];
    logic                                m_valid_reg;
    vunb_pkg::out_beat_t                 m_data_reg;

    logic          wr_ok;
    logic [AW-1:0] waddr;
    logic          hit, last;
    logic [CW-1:0] ch_idx;
    logic [PW-1:0] cur, delta, step, next_pos;
    logic          up;

    assign waddr  = AW'(s_data.entry_index);
    assign wr_ok  = (32'(s_data.entry_index) < NEEDLE_STEPS);
    assign ch_idx = CW'(chan_reg);

    assign status.is_write  = (s_data.operation == vunb_pkg::OP_WRITE);
    assign status.chan_ok   = (32'(s_data.channel) < CHANNELS);
    assign hit              = rvalid_reg && (rdata_reg >= level_reg);
    assign last             = rvalid_reg && (ridx_reg == AW'(NEEDLE_STEPS - 1));
    assign status.scan_done = hit || last;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign addr_next = (addr_reg == AW'(NEEDLE_STEPS - 1)) ? addr_reg : addr_reg + AW'(1);

    // table store and registered scan read
    always_ff @(posedge aclk) begin
        if (cmd.table_wr && wr_ok) begin
            table_mem[waddr] <= s_data.entry_value;
        end
        if (cmd.scan) begin
            rdata_reg <= table_mem[addr_reg];
            ridx_reg  <= addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            rvalid_reg <= 1'b0;
        end else if (cmd.scan) begin
            rvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            level_reg <= s_data.level_db;
            chan_reg  <= s_data.channel;
            addr_reg  <= '0;
        end else if (cmd.scan) begin
            addr_reg <= addr_next;
        end
        if (cmd.scan && status.scan_done) begin
            target_reg <= hit ? PW'(ridx_reg) : PW'(NEEDLE_STEPS);
        end
    end

    // slew step
    always_comb begin
        cur   = needle_reg[ch_idx];
        up    = (target_reg > cur);
        delta = up ? (target_reg - cur) : (cur - target_reg);
        if (delta <= PW'(2)) begin
            step = delta;
        end else if (delta < PW'(7)) begin
            step = PW'(3);
        end else if (delta < PW'(10)) begin
            step = PW'(6);
        end else begin
            step = PW'(8);
        end
        next_pos = up ? (cur + step) : (cur - step);
        if (next_pos > PW'(NEEDLE_STEPS - 1)) begin
            next_pos = PW'(NEEDLE_STEPS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                needle_reg[i] <= '0;
            end
        end else if (cmd.update) begin
            needle_reg[ch_idx] <= next_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_data_reg.out_channel     <= chan_reg;
            m_data_reg.needle_position <= vunb_pkg::POS_W'(next_pos);
            m_data_reg.target_position <= vunb_pkg::POS_W'(target_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/vunb_ctrl.sv =====
module vunb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vunb_pkg::dp_status_t status,
    output vunb_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_SLEW = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.table_wr = 1'b0;
        cmd.load     = 1'b0;
        cmd.scan     = 1'b0;
        cmd.update   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.table_wr = accept && status.is_write;
                cmd.load     = accept && !status.is_write && status.chan_ok;
                if (cmd.load) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW: begin
                cmd.update = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
